[rtl/bdc_pkg.sv]
// Shared types and constants for the byte delta codec.
// No dependencies; every other rtl file imports this package.
`default_nettype none

package bdc_pkg;

	// Operating modes held in the mode register.
	localparam logic [1:0] MODE_SELF_ENC = 2'd0;
	localparam logic [1:0] MODE_SELF_DEC = 2'd1;
	localparam logic [1:0] MODE_REF_ENC  = 2'd2;
	localparam logic [1:0] MODE_REF_DEC  = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_MSG_LEN = 2'd1;
	localparam logic [1:0] REG_REF_LEN = 2'd2;

	// Header sizes in bytes.
	localparam logic [3:0] HDR_SELF = 4'd4;
	localparam logic [3:0] HDR_REF  = 4'd8;

	// Queue depth and pointer width.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	// One queued job: header bytes to send, then an optional payload byte.
	typedef struct packed {
		logic [3:0]  hdr_n;
		logic [31:0] word0;
		logic [31:0] word1;
		logic        pay;
		logic [7:0]  pay_byte;
		logic        fin;
	} qent_t;

endpackage

`default_nettype wire

[rtl/bdc_front.sv]
// Front end of the byte delta codec: config registers, header parsing and
// per-byte delta arithmetic. Produces at most one queue entry per accepted beat.
// Depends on bdc_pkg.
`default_nettype none

module bdc_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_valid,
	output logic             cfg_ready,
	input  wire [1:0]        cfg_index,
	input  wire [31:0]       cfg_data,
	input  wire              in_fire,
	input  wire [7:0]        data_byte,
	input  wire [7:0]        ref_byte,
	input  wire              last_in,
	output logic             push,
	output bdc_pkg::qent_t   push_ent
);
	import bdc_pkg::*;

	logic [1:0]  mode_q;
	logic [31:0] msg_len_q;
	logic [31:0] ref_len_q;

	logic [7:0]  prev_q;
	logic [31:0] idx_q;
	logic [3:0]  hc_q;
	logic [31:0] dlen_q;

	logic        enc;
	logic        send_hdr;
	logic [3:0]  hc_enc;
	logic [3:0]  hdr_lim;
	logic        dec_hdr;
	logic        in_ref;
	logic [31:0] len_sel;
	logic [31:0] idx_inc;
	logic [7:0]  pay_byte;
	logic        pay;
	logic [31:0] dlen_nxt;
	qent_t       ent;

	assign cfg_ready = 1'b1;

	// Configuration register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_SELF_ENC;
			msg_len_q <= '0;
			ref_len_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:    mode_q    <= cfg_data[1:0];
				REG_MSG_LEN: msg_len_q <= cfg_data;
				REG_REF_LEN: ref_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Classify the beat and compute its payload byte.
	always_comb begin
		enc      = !mode_q[0];
		send_hdr = enc && (msg_len_q != '0) && (hc_q == '0);
		hc_enc   = send_hdr ? (mode_q[1] ? HDR_REF : HDR_SELF) : hc_q;
		hdr_lim  = mode_q[1] ? HDR_REF : HDR_SELF;
		dec_hdr  = !enc && (hc_q < hdr_lim);
		in_ref   = idx_q < ref_len_q;
		len_sel  = enc ? msg_len_q : dlen_q;
		idx_inc  = idx_q + 32'd1;

		if (enc) begin
			pay = (hc_enc != '0) && (idx_q < msg_len_q);
		end else begin
			pay = !dec_hdr && (idx_q < dlen_q);
		end

		case (mode_q)
			MODE_SELF_ENC: pay_byte = data_byte - prev_q;
			MODE_SELF_DEC: pay_byte = data_byte + prev_q;
			MODE_REF_ENC:  pay_byte = in_ref ? (data_byte - ref_byte) : data_byte;
			MODE_REF_DEC:  pay_byte = in_ref ? (data_byte + ref_byte) : data_byte;
			default:       pay_byte = data_byte;
		endcase

		// Length header bytes arrive little endian, one byte lane at a time.
		dlen_nxt = dlen_q;
		if (dec_hdr && (hc_q[3:2] == 2'b00)) begin
			case (hc_q[1:0])
				2'd0:    dlen_nxt[7:0]   = data_byte;
				2'd1:    dlen_nxt[15:8]  = data_byte;
				2'd2:    dlen_nxt[23:16] = data_byte;
				2'd3:    dlen_nxt[31:24] = data_byte;
				default: dlen_nxt = dlen_q;
			endcase
		end

		ent.hdr_n    = send_hdr ? hc_enc : 4'd0;
		ent.word0    = msg_len_q;
		ent.word1    = ref_len_q;
		ent.pay      = pay;
		ent.pay_byte = pay_byte;
		ent.fin      = last_in || (idx_inc == len_sel);
	end

	assign push     = in_fire && (send_hdr || pay);
	assign push_ent = ent;

	// Message state; the final beat of a message clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			idx_q  <= '0;
			hc_q   <= '0;
			dlen_q <= '0;
		end else if (in_fire) begin
			if (last_in) begin
				prev_q <= '0;
				idx_q  <= '0;
				hc_q   <= '0;
				dlen_q <= '0;
			end else begin
				if (enc) begin
					hc_q <= hc_enc;
				end else if (dec_hdr) begin
					hc_q <= hc_q + 4'd1;
				end
				dlen_q <= dlen_nxt;
				if (pay) begin
					idx_q <= idx_inc;
					if (mode_q == MODE_SELF_ENC) begin
						prev_q <= data_byte;
					end else if (mode_q == MODE_SELF_DEC) begin
						prev_q <= pay_byte;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

[rtl/bdc_queue.sv]
// Short job queue between the codec front end and the output sequencer.
// Depends on bdc_pkg.
`default_nettype none

module bdc_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  bdc_pkg::qent_t   push_ent,
	output logic             full,
	output logic             head_valid,
	output bdc_pkg::qent_t   head,
	input  wire              pop
);
	import bdc_pkg::*;

	qent_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full       = (cnt_q == QDEPTH[QPTR_W:0]);
	assign head_valid = (cnt_q != '0);
	assign head       = slot_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_ent;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/bdc_back.sv]
// Output sequencer: walks each queued job through its header bytes and
// payload byte into the output register. Depends on bdc_pkg.
`default_nettype none

module bdc_back (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              head_valid,
	input  bdc_pkg::qent_t   head,
	output logic             pop,
	output logic             out_valid,
	input  wire              out_ready,
	output logic [7:0]       out_byte,
	output logic             last_out
);
	import bdc_pkg::*;

	logic [3:0]  seq_q;
	logic        ovld_q;
	logic [7:0]  obyte_q;
	logic        olast_q;

	logic        emit;
	logic        is_hdr;
	logic        end_job;
	logic [31:0] wsel;
	logic [7:0]  hbyte;
	logic [7:0]  nbyte;
	logic        nlast;

	// Pick the next beat of the head job.
	always_comb begin
		emit   = head_valid && (!ovld_q || out_ready);
		is_hdr = seq_q < head.hdr_n;
		wsel   = seq_q[2] ? head.word1 : head.word0;
		case (seq_q[1:0])
			2'd0:    hbyte = wsel[7:0];
			2'd1:    hbyte = wsel[15:8];
			2'd2:    hbyte = wsel[23:16];
			2'd3:    hbyte = wsel[31:24];
			default: hbyte = wsel[7:0];
		endcase
		nbyte   = is_hdr ? hbyte : head.pay_byte;
		nlast   = !is_hdr && head.fin;
		end_job = is_hdr ? ((seq_q == head.hdr_n - 4'd1) && !head.pay) : 1'b1;
		pop     = emit && end_job;
	end

	// Beat counter within the head job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
		end else if (emit) begin
			seq_q <= end_job ? 4'd0 : seq_q + 4'd1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (emit) begin
			ovld_q <= 1'b1;
		end else if (out_ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			obyte_q <= nbyte;
			olast_q <= nlast;
		end
	end

	assign out_valid = ovld_q;
	assign out_byte  = obyte_q;
	assign last_out  = olast_q;

endmodule

`default_nettype wire

[rtl/byte_delta_codec_top.sv]
// Top level of the byte delta codec: front end, job queue, output sequencer.
// Depends on bdc_pkg, bdc_front, bdc_queue and bdc_back.
//
//  Channel  Handshake              Beat contents
//  cfg      cfg_valid/cfg_ready    cfg_index (register), cfg_data
//  in       in_valid/in_ready      data_byte, ref_byte, last_in
//  out      out_valid/out_ready    out_byte, last_out
//
// A payload beat is held in a job queue slot and then in the output register;
// the codec streams one byte per cycle while out_ready is held high. An
// encoder beat that opens a message also sends its header, four (self) or
// eight (reference) bytes ahead of its payload byte. Throughput is set by the
// one-byte-per-cycle output register; a two-entry job queue lets the front keep
// accepting while the output is stalled, until it fills. Reset clears config
// and message state; config writes are taken every cycle.
`default_nettype none

module byte_delta_codec_top (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [1:0]  cfg_index,
	input  wire [31:0] cfg_data,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire [7:0]  data_byte,
	input  wire [7:0]  ref_byte,
	input  wire        last_in,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] out_byte,
	output logic       last_out
);
	import bdc_pkg::*;

	logic  in_fire;
	logic  push;
	qent_t push_ent;
	logic  full;
	logic  head_valid;
	qent_t head;
	logic  pop;

	assign in_ready = !full;
	assign in_fire  = in_valid && in_ready;

	bdc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_fire   (in_fire),
		.data_byte (data_byte),
		.ref_byte  (ref_byte),
		.last_in   (last_in),
		.push      (push),
		.push_ent  (push_ent)
	);

	bdc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ent   (push_ent),
		.full       (full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	bdc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last_out   (last_out)
	);

endmodule

`default_nettype wire
